// ===== rtl/core/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Table geometry and field widths
  localparam int MaxTasks = 16;
  localparam int TimeBits = 40;
  localparam int IdW      = 16;
  localparam int PerW     = 16;
  localparam int ActW     = 2;
  localparam int StatW    = 2;
  localparam int IdxW     = $clog2(MaxTasks);
  localparam int CntW     = $clog2(MaxTasks + 1);

  // Request codes
  typedef enum logic [ActW-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_NEXT  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_UPDATE = 2'd2,
    S_RESP   = 2'd3
  } state_e;

  // One table entry
  typedef struct packed {
    logic [IdW-1:0]      id;
    logic [PerW-1:0]     period;
    logic [TimeBits-1:0] due;
  } entry_t;

endpackage

// ===== rtl/core/periodic_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_scheduler
// Task table in a single-port-write, registered-read memory; a next request
// scans it with one comparator, writes back the advanced due time if it fits.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o | action_i, task_id_i, period_i
//  out     | out_valid_o/out_ready_i | fired_id_o, fire_time_o, status_o
//
//  Clear, add and unused requests go from the accept state straight to the
//  result state, which loads the output register once it is free.
//  A next request passes through the accept state, one memory read per
//  entry through the single read port and comparator, then write-back,
//  then the result state, which loads the output register once it is free.
//  Reset empties the table at once; entry contents are not cleared.
//  A result waiting on out_ready_i does not block the next request from
//  being accepted; the block stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module periodic_task_scheduler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pts_pkg::ActW-1:0]   action_i,
  input  logic [pts_pkg::IdW-1:0]    task_id_i,
  input  logic [pts_pkg::PerW-1:0]   period_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pts_pkg::IdW-1:0]    fired_id_o,
  output logic [pts_pkg::TimeBits-1:0] fire_time_o,
  output logic [pts_pkg::StatW-1:0]  status_o
);
  import pts_pkg::*;

  // Table memory
  entry_t mem_q [MaxTasks];
  entry_t rd_data_q;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic            rd_en, wr_en;
  entry_t          wr_data;

  // Control and working registers
  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     scan_q, scan_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  entry_t              best_q, best_d;
  logic [IdW-1:0]      res_id_q, res_id_d;
  logic [TimeBits-1:0] res_time_q, res_time_d;
  status_e             res_stat_q, res_stat_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [IdW-1:0]      out_id_q;
  logic [TimeBits-1:0] out_time_q;
  status_e             out_stat_q;

  action_e             act;
  logic [CntW-1:0]     scan_nxt;
  logic                take;
  logic [TimeBits:0]   due_sum;

  assign act      = action_e'(action_i);
  assign scan_nxt = scan_q + CntW'(1);
  assign take     = (scan_q == '0) || (rd_data_q.due < best_q.due) ||
                    ((rd_data_q.due == best_q.due) && (rd_data_q.id < best_q.id));
  assign due_sum  = {1'b0, best_q.due} + (TimeBits+1)'(best_q.period);

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Sequencer: next state, memory controls and result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    res_id_d   = res_id_q;
    res_time_d = res_time_q;
    res_stat_d = res_stat_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = count_q[IdxW-1:0];
    wr_data    = '0;
    in_ready_o = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_id_d   = '0;
          res_time_d = '0;
          res_stat_d = STAT_OK;
          state_d    = S_RESP;
          case (act)
            ACT_CLEAR: begin
              count_d = '0;
            end
            ACT_ADD: begin
              if (count_q >= CntW'(MaxTasks)) begin
                res_stat_d = STAT_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_data.id     = task_id_i;
                wr_data.period = period_i;
                wr_data.due    = TimeBits'(period_i);
                count_d        = count_q + CntW'(1);
              end
            end
            ACT_NEXT: begin
              if (count_q == '0) begin
                res_stat_d = STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                scan_d  = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_stat_d = STAT_OK;
            end
          endcase
        end
      end

      // One entry per cycle through the comparator
      S_SCAN: begin
        if (take) begin
          best_d     = rd_data_q;
          best_idx_d = scan_q[IdxW-1:0];
        end
        if (scan_nxt < count_q) begin
          rd_en   = 1'b1;
          rd_addr = scan_nxt[IdxW-1:0];
          scan_d  = scan_nxt;
        end else begin
          state_d = S_UPDATE;
        end
      end

      // Advance the winner unless the sum leaves the time range
      S_UPDATE: begin
        res_id_d   = best_q.id;
        res_time_d = best_q.due;
        if (due_sum[TimeBits]) begin
          res_stat_d = STAT_OVERFLOW;
        end else begin
          res_stat_d     = STAT_OK;
          wr_en          = 1'b1;
          wr_addr        = best_idx_q;
          wr_data.id     = best_q.id;
          wr_data.period = best_q.period;
          wr_data.due    = due_sum[TimeBits-1:0];
        end
        state_d = S_RESP;
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_id_q   <= res_id_d;
    res_time_q <= res_time_d;
    res_stat_q <= res_stat_d;
    if (out_load) begin
      out_id_q   <= res_id_q;
      out_time_q <= res_time_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fired_id_o  = out_id_q;
  assign fire_time_o = out_time_q;
  assign status_o    = out_stat_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for periodic_task_scheduler. A request queue feeds a
// valid/ready driver with random gaps. A scoreboard predicts each result from
// its own copy of the task table, and a monitor compares every result field
// by field under random output stalls.
// ----------------------------------------------------------------------------
module tb;
  import pts_pkg::*;

  // Request and result records
  typedef struct packed {
    action_e         act;
    logic [IdW-1:0]  tid;
    logic [PerW-1:0] per;
  } sched_req_t;

  typedef struct packed {
    logic [IdW-1:0]      id;
    logic [TimeBits-1:0] when;
    status_e             st;
  } firing_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [ActW-1:0]     action_i    = '0;
  logic [IdW-1:0]      task_id_i   = '0;
  logic [PerW-1:0]     period_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [IdW-1:0]      fired_id_o;
  logic [TimeBits-1:0] fire_time_o;
  logic [StatW-1:0]    status_o;

  periodic_task_scheduler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .task_id_i  (task_id_i),
    .period_i   (period_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .fired_id_o (fired_id_o),
    .fire_time_o(fire_time_o),
    .status_o   (status_o)
  );

  // Scoreboard copy of the task table
  logic [IdW-1:0]      id_tab  [MaxTasks];
  logic [PerW-1:0]     per_tab [MaxTasks];
  logic [TimeBits-1:0] due_tab [MaxTasks];
  int                  task_cnt = 0;

  sched_req_t pending_q[$];
  firing_t    firing_q[$];

  int  errors      = 0;
  int  checked     = 0;
  int  fired_cnt   = 0;
  int  empty_cnt   = 0;
  int  full_cnt    = 0;
  int  ovf_cnt     = 0;
  bit  req_taken   = 1'b0;
  bit  idle_on     = 1'b1;
  int  in_gap      = 0;
  int  out_stall   = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Compute the result of one accepted request and update the table copy
  task automatic schedule_request(input action_e act, input logic [IdW-1:0] tid,
                                  input logic [PerW-1:0] per);
    firing_t         r;
    int              best;
    logic [TimeBits:0] sum;
    r    = '0;
    r.st = STAT_OK;
    case (act)
      ACT_CLEAR: begin
        task_cnt = 0;
      end
      ACT_ADD: begin
        if (task_cnt >= MaxTasks) begin
          r.st = STAT_FULL;
          full_cnt++;
        end else begin
          id_tab[task_cnt]  = tid;
          per_tab[task_cnt] = per;
          due_tab[task_cnt] = TimeBits'(per);
          task_cnt++;
        end
      end
      ACT_NEXT: begin
        if (task_cnt == 0) begin
          r.st = STAT_EMPTY;
          empty_cnt++;
        end else begin
          best = 0;
          // earliest due time, ties to the smaller id, then lowest slot
          for (int i = 1; i < task_cnt; i++) begin
            if (due_tab[i] < due_tab[best] ||
                (due_tab[i] == due_tab[best] && id_tab[i] < id_tab[best]))
              best = i;
          end
          r.id   = id_tab[best];
          r.when = due_tab[best];
          sum    = {1'b0, due_tab[best]} + (TimeBits + 1)'(per_tab[best]);
          if (sum[TimeBits]) begin
            r.st = STAT_OVERFLOW;
            ovf_cnt++;
          end else begin
            due_tab[best] = sum[TimeBits-1:0];
            fired_cnt++;
          end
        end
      end
      default: ;
    endcase
    firing_q.push_back(r);
  endtask

  // Compare one accepted result against the oldest prediction
  task automatic check_firing();
    firing_t want;
    checked++;
    if (firing_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR %0t: unexpected result id=%h time=%h status=%0d",
                 $realtime, fired_id_o, fire_time_o, status_o);
    end else begin
      want = firing_q.pop_front();
      if (fired_id_o !== want.id || fire_time_o !== want.when ||
          status_o !== want.st) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: exp id=%h time=%h status=%0d, got id=%h time=%h status=%0d",
                   $realtime, want.id, want.when, want.st,
                   fired_id_o, fire_time_o, status_o);
      end
    end
  endtask

  // Monitor: accept requests and results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        schedule_request(action_e'(action_i), task_id_i, period_i);
        req_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i)
        check_firing();
    end
  end

  // Request driver: changes inputs at the falling edge
  always @(negedge clk_i) begin
    sched_req_t nxt;
    if (pending_q.size() < 120)
      idle_on = 1'b0;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        in_gap = $urandom_range(1, 5) - 1;
        in_valid_i <= 1'b0;
      end else begin
        nxt = pending_q.pop_front();
        in_valid_i <= 1'b1;
        action_i   <= nxt.act;
        task_id_i  <= nxt.tid;
        period_i   <= nxt.per;
      end
    end
  end

  // Result-side stalls
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_stall = $urandom_range(1, 5) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void push_req(action_e act, logic [IdW-1:0] tid,
                                   logic [PerW-1:0] per);
    sched_req_t r;
    r.act = act;
    r.tid = tid;
    r.per = per;
    pending_q.push_back(r);
  endfunction

  // Mostly a small id pool so that ties and duplicates show up
  function automatic logic [IdW-1:0] rand_task_id();
    if ($urandom_range(0, 3) == 0)
      return IdW'($urandom);
    return IdW'($urandom_range(0, 7));
  endfunction

  // Mostly short periods; now and then zero or full range
  function automatic logic [PerW-1:0] rand_period();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      return '0;
    if (pick <= 2)
      return PerW'($urandom);
    return PerW'($urandom_range(1, 12));
  endfunction

  // Stimulus and end of run
  initial begin
    int      rnd_items;
    int      n_add;
    int      n_next;
    action_e act;

    // Directed: empty table, unused code, extremes, ties, zero period, full
    push_req(ACT_NEXT,  16'h0000, 16'h0000);
    push_req(ACT_NONE,  16'hFFFF, 16'hFFFF);
    push_req(ACT_ADD,   16'hFFFF, 16'hFFFF);
    push_req(ACT_ADD,   16'h0000, 16'h0001);
    push_req(ACT_ADD,   16'h0000, 16'h0001);
    push_req(ACT_NEXT,  16'hFFFF, 16'hFFFF);
    push_req(ACT_NEXT,  16'h0000, 16'h0000);
    push_req(ACT_NEXT,  16'h0000, 16'h0000);
    push_req(ACT_ADD,   16'h0005, 16'h0000);
    push_req(ACT_NEXT,  16'h0000, 16'h0000);
    push_req(ACT_NEXT,  16'h0000, 16'h0000);
    for (int i = 0; i < MaxTasks - 4; i++)
      push_req(ACT_ADD, IdW'(16'h8000 + i), PerW'(i + 2));
    push_req(ACT_ADD,   16'h1234, 16'h0007);
    push_req(ACT_NEXT,  16'h0000, 16'h0000);
    push_req(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
    push_req(ACT_NEXT,  16'h0000, 16'h0000);

    // Random: mostly clear / fill / drain episodes, some loose noise
    rnd_items = 0;
    while (rnd_items < 1550) begin
      if ($urandom_range(0, 6) != 0) begin
        push_req(ACT_CLEAR, IdW'($urandom), PerW'($urandom));
        n_add  = $urandom_range(1, MaxTasks + 2);
        n_next = $urandom_range(1, 30);
        for (int i = 0; i < n_add; i++)
          push_req(ACT_ADD, rand_task_id(), rand_period());
        for (int i = 0; i < n_next; i++) begin
          if ($urandom_range(0, 9) == 0)
            push_req(ACT_ADD, rand_task_id(), rand_period());
          else
            push_req(ACT_NEXT, IdW'($urandom), PerW'($urandom));
        end
        rnd_items += 1 + n_add + n_next;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          act = action_e'($urandom_range(0, 3));
          push_req(act, IdW'($urandom), PerW'($urandom));
          if (act != ACT_NONE)
            rnd_items++;
        end
      end
    end

    // Apply reset, then release it away from the rising edge
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all requests accepted, all results back, then settle
    while (pending_q.size() != 0 || in_valid_i)
      @(negedge clk_i);
    while (firing_q.size() != 0)
      @(negedge clk_i);
    repeat (MaxTasks + 10) @(posedge clk_i);
    @(negedge clk_i);
    errors += firing_q.size();

    $display("Checked %0d results: %0d firings, %0d empty-table, %0d full-table,",
             checked, fired_cnt, empty_cnt, full_cnt);
    $display("%0d overflow; %0d mismatches in total", ovf_cnt, errors);
    if (errors == 0) begin
      $display("PASS periodic_task_scheduler");
    end else begin
      $display("FAIL periodic_task_scheduler");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Timeout: %0d results still outstanding", firing_q.size());
    $display("FAIL periodic_task_scheduler");
    $finish;
  end

endmodule
